// ----- rtl/rcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// rcpg_pkg
// Shared constants, types and helpers for the ratio clock phase generator.
// ----------------------------------------------------------------------------
package rcpg_pkg;

	localparam int OUTPUT_COUNT = 4;
	localparam int PHASE_BITS   = 24;

	localparam int PACK_N    = 4;
	localparam int MASK_W    = 4;
	localparam int BEAT_W    = 32;
	localparam int RATIO_W   = 8;
	localparam int RUN_W     = 2;
	localparam int INC_W     = 24;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 8;
	localparam int RUNS_W    = 8;
	localparam int IDX_W     = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
	localparam int POS_W     = PHASE_BITS + RATIO_W;
	localparam int PROD_W    = POS_W + RATIO_W;
	localparam int CNT_W     = $clog2(PROD_W);
	localparam int OPH_W     = PHASE_BITS + 1;

	localparam logic [OPH_W-1:0] ONE_PHASE = {1'b1, {PHASE_BITS{1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_INC  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUMS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DENS = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_RUNS = CFG_IDX_W'(3);

	localparam logic [RUN_W-1:0] RUN_OFF  = 2'd0;
	localparam logic [RUN_W-1:0] RUN_LOOP = 2'd1;
	localparam logic [RUN_W-1:0] RUN_MIDI = 2'd2;
	localparam logic [RUN_W-1:0] RUN_ONE  = 2'd3;

	localparam logic [INC_W-1:0]  INC_RST   = '0;
	localparam logic [CFG_W-1:0]  RATIO_RST = 32'h0101_0101;
	localparam logic [RUNS_W-1:0] RUNS_RST  = 8'h55;

	typedef struct packed {
		logic [INC_W-1:0]  inc;
		logic [CFG_W-1:0]  nums;
		logic [CFG_W-1:0]  dens;
		logic [RUNS_W-1:0] runs;
	} cfg_t;

	typedef struct packed {
		logic              timeout;
		logic              playing;
		logic              internal_clock;
		logic [MASK_W-1:0] allow;
		logic [MASK_W-1:0] rel_mask;
	} item_t;

	typedef struct packed {
		logic [MASK_W-1:0] fired;
		logic [MASK_W-1:0] gates;
		logic [BEAT_W-1:0] beat;
	} res_t;

	function automatic logic [RATIO_W-1:0] ratio_of(input logic [CFG_W-1:0] w,
			input logic [IDX_W-1:0] idx);
		logic [RATIO_W-1:0] r;
		r = '0;
		for (int k = 0; k < PACK_N; k++)
			if (int'(idx) == k) r = w[k*RATIO_W +: RATIO_W];
		return r;
	endfunction

	function automatic logic [RUN_W-1:0] run_of(input logic [RUNS_W-1:0] w,
			input logic [IDX_W-1:0] idx);
		logic [RUN_W-1:0] r;
		r = RUN_OFF;
		for (int k = 0; k < PACK_N; k++)
			if (int'(idx) == k) r = w[k*RUN_W +: RUN_W];
		return r;
	endfunction

	function automatic logic [OUTPUT_COUNT-1:0] ext_mask(input logic [MASK_W-1:0] m);
		logic [OUTPUT_COUNT-1:0] r;
		r = '0;
		for (int k = 0; k < OUTPUT_COUNT; k++)
			if (k < MASK_W) r[k] = m[k];
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] out_mask(input logic [OUTPUT_COUNT-1:0] m);
		logic [MASK_W-1:0] r;
		r = '0;
		for (int k = 0; k < MASK_W; k++)
			if (k < OUTPUT_COUNT) r[k] = m[k];
		return r;
	endfunction

endpackage

// ----- rtl/ratio_clock_phase_generator.sv -----
// ----------------------------------------------------------------------------
// ratio_clock_phase_generator
// Ratio clock multiplier/divider driven by a fractional master phase.
// ----------------------------------------------------------------------------
//  channel  signals                                            dir
//  cfg      cfg_valid cfg_ready cfg_index cfg_data             in
//  in       in_valid in_ready mode playing internal_clock      in
//           retrigger_allow gate_release
//  out      out_valid out_ready fired_mask gate_mask beat_count out
//
//  A tick runs the per-output pass once for each output; loop-like outputs
//  go through the shared 8-bit division step, running 32 steps for beat
//  mod den and 40 for the phase quotient. Timeout and idle ticks skip the
//  per-output pass. No clearing pass after reset.
//  in_ready is low while a request is in work; a finished result waits in
//  the engine, which holds until the output register is free.
// ----------------------------------------------------------------------------
module ratio_clock_phase_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcpg_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic                              playing,
	input  logic                              internal_clock,
	input  logic [rcpg_pkg::MASK_W-1:0]       retrigger_allow,
	input  logic [rcpg_pkg::MASK_W-1:0]       gate_release,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rcpg_pkg::MASK_W-1:0]       fired_mask,
	output logic [rcpg_pkg::MASK_W-1:0]       gate_mask,
	output logic [rcpg_pkg::BEAT_W-1:0]       beat_count
);

	rcpg_pkg::cfg_t  cfg_q;
	rcpg_pkg::item_t item;
	rcpg_pkg::res_t  res;
	logic            core_idle;
	logic            res_valid;
	logic            res_take;
	logic            out_valid_q;
	rcpg_pkg::res_t  out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inc  <= rcpg_pkg::INC_RST;
			cfg_q.nums <= rcpg_pkg::RATIO_RST;
			cfg_q.dens <= rcpg_pkg::RATIO_RST;
			cfg_q.runs <= rcpg_pkg::RUNS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcpg_pkg::REG_INC:  cfg_q.inc  <= cfg_data[rcpg_pkg::INC_W-1:0];
				rcpg_pkg::REG_NUMS: cfg_q.nums <= cfg_data;
				rcpg_pkg::REG_DENS: cfg_q.dens <= cfg_data;
				rcpg_pkg::REG_RUNS: cfg_q.runs <= cfg_data[rcpg_pkg::RUNS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		item.timeout        = mode;
		item.playing        = playing;
		item.internal_clock = internal_clock;
		item.allow          = retrigger_allow;
		item.rel_mask       = gate_release;
	end

	assign in_ready = core_idle;
	assign res_take = res_valid && (!out_valid_q || out_ready);

	rcpg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid && in_ready),
		.item      (item),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign fired_mask = out_q.fired;
	assign gate_mask  = out_q.gates;
	assign beat_count = out_q.beat;

	a_fired_in_gates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fired_mask & ~gate_mask) == '0))
		else $error("fired bit without gate high");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine ready straight after a request");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid_q && !out_ready) |=> (res_valid && $stable(res)))
		else $error("finished result dropped while output register full");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_idle |-> !res_valid)
		else $error("result shown while engine idle");

endmodule

// ----- rtl/rcpg_divstep.sv -----
// ----------------------------------------------------------------------------
// rcpg_divstep
// One restoring division step by an 8-bit divisor: shift in a bit, trial
// subtract, emit quotient bit.
// ----------------------------------------------------------------------------
module rcpg_divstep (
	input  logic [rcpg_pkg::RATIO_W-1:0] rem,
	input  logic                         bit_in,
	input  logic [rcpg_pkg::RATIO_W-1:0] den,
	output logic [rcpg_pkg::RATIO_W-1:0] rem_nxt,
	output logic                         qbit
);

	logic [rcpg_pkg::RATIO_W:0] trial;
	logic [rcpg_pkg::RATIO_W:0] diff;

	always_comb begin
		trial   = {rem, bit_in};
		diff    = trial - {1'b0, den};
		qbit    = (trial >= {1'b0, den});
		rem_nxt = qbit ? diff[rcpg_pkg::RATIO_W-1:0] : trial[rcpg_pkg::RATIO_W-1:0];
	end

endmodule

// ----- rtl/rcpg_core.sv -----
// ----------------------------------------------------------------------------
// rcpg_core
// Phase state and sequencer: while playing, advances the master phase, then
// derives each loop-like output phase through the shared division step (beat
// mod den, multiply, long division) and raises allowed gates on wrap.
// ----------------------------------------------------------------------------
module rcpg_core (
	input  logic                clk,
	input  logic                arst_n,
	input  rcpg_pkg::cfg_t      cfg,
	input  logic                start,
	input  rcpg_pkg::item_t     item,
	output logic                idle,
	output logic                res_valid,
	output rcpg_pkg::res_t      res,
	input  logic                res_take
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEL  = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_CMP  = 3'd5;
	localparam logic [2:0] ST_NEXT = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]                           st_q;
	logic [rcpg_pkg::PHASE_BITS-1:0]      mp_q;
	logic [rcpg_pkg::BEAT_W-1:0]          beat_q;
	logic [rcpg_pkg::OPH_W-1:0]           oph_q [rcpg_pkg::OUTPUT_COUNT];
	logic [rcpg_pkg::OUTPUT_COUNT-1:0]    gate_q;
	logic [rcpg_pkg::OUTPUT_COUNT-1:0]    fired_q;
	logic [rcpg_pkg::OUTPUT_COUNT-1:0]    allow_q;
	logic                                 internal_q;
	logic [rcpg_pkg::IDX_W-1:0]           idx_q;
	logic [rcpg_pkg::CNT_W-1:0]           cnt_q;
	logic [rcpg_pkg::PROD_W-1:0]          sh_q;
	logic [rcpg_pkg::RATIO_W-1:0]         rem_q;

	logic [rcpg_pkg::PHASE_BITS-1:0]      inc;
	logic [rcpg_pkg::PHASE_BITS:0]        mp_sum;
	logic [rcpg_pkg::RATIO_W-1:0]         num;
	logic [rcpg_pkg::RATIO_W-1:0]         den_raw;
	logic [rcpg_pkg::RATIO_W-1:0]         den;
	logic [rcpg_pkg::RUN_W-1:0]           run;
	logic                                 loop_like;
	logic [rcpg_pkg::RATIO_W-1:0]         rem_nxt;
	logic                                 qbit;
	logic [rcpg_pkg::PHASE_BITS-1:0]      np;
	logic                                 wrapped;
	logic [rcpg_pkg::PROD_W-1:0]          prod;

	always_comb begin
		inc       = rcpg_pkg::PHASE_BITS'(cfg.inc);
		mp_sum    = {1'b0, mp_q} + {1'b0, inc};
		num       = rcpg_pkg::ratio_of(cfg.nums, idx_q);
		den_raw   = rcpg_pkg::ratio_of(cfg.dens, idx_q);
		den       = (den_raw == '0) ? rcpg_pkg::RATIO_W'(1) : den_raw;
		run       = rcpg_pkg::run_of(cfg.runs, idx_q);
		loop_like = (run == rcpg_pkg::RUN_LOOP) ||
			((run == rcpg_pkg::RUN_MIDI) && internal_q);
		np        = sh_q[rcpg_pkg::PHASE_BITS-1:0];
		wrapped   = {1'b0, np} < oph_q[idx_q];
		prod      = rcpg_pkg::PROD_W'({rem_q, mp_q}) * rcpg_pkg::PROD_W'(num);
	end

	rcpg_divstep u_divstep (
		.rem     (rem_q),
		.bit_in  (sh_q[rcpg_pkg::PROD_W-1]),
		.den     (den),
		.rem_nxt (rem_nxt),
		.qbit    (qbit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			mp_q       <= '0;
			beat_q     <= '0;
			gate_q     <= '0;
			fired_q    <= '0;
			allow_q    <= '0;
			internal_q <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
			sh_q       <= '0;
			rem_q      <= '0;
			for (int k = 0; k < rcpg_pkg::OUTPUT_COUNT; k++) oph_q[k] <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						gate_q     <= gate_q & ~rcpg_pkg::ext_mask(item.rel_mask);
						allow_q    <= rcpg_pkg::ext_mask(item.allow);
						internal_q <= item.internal_clock;
						fired_q    <= '0;
						idx_q      <= '0;
						if (item.timeout) begin
							for (int k = 0; k < rcpg_pkg::OUTPUT_COUNT; k++) begin
								if ((rcpg_pkg::run_of(cfg.runs, rcpg_pkg::IDX_W'(k)) ==
										rcpg_pkg::RUN_LOOP) ||
										(rcpg_pkg::run_of(cfg.runs, rcpg_pkg::IDX_W'(k)) ==
										rcpg_pkg::RUN_MIDI))
									oph_q[k] <= rcpg_pkg::ONE_PHASE;
							end
							st_q <= ST_DONE;
						end else if (item.playing && (inc != '0)) begin
							mp_q <= mp_sum[rcpg_pkg::PHASE_BITS-1:0];
							if (mp_sum[rcpg_pkg::PHASE_BITS]) beat_q <= beat_q + 1'b1;
							st_q <= ST_SEL;
						end else begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_SEL: begin
					rem_q <= '0;
					sh_q  <= {beat_q, {(rcpg_pkg::PROD_W-rcpg_pkg::BEAT_W){1'b0}}};
					cnt_q <= rcpg_pkg::CNT_W'(rcpg_pkg::BEAT_W - 1);
					st_q  <= loop_like ? ST_MOD : ST_NEXT;
				end
				ST_MOD: begin
					rem_q <= rem_nxt;
					sh_q  <= {sh_q[rcpg_pkg::PROD_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) st_q <= ST_MUL;
				end
				ST_MUL: begin
					sh_q  <= prod;
					rem_q <= '0;
					cnt_q <= rcpg_pkg::CNT_W'(rcpg_pkg::PROD_W - 1);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					sh_q  <= {sh_q[rcpg_pkg::PROD_W-2:0], qbit};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) st_q <= ST_CMP;
				end
				ST_CMP: begin
					oph_q[idx_q] <= {1'b0, np};
					if (wrapped && !gate_q[idx_q] && allow_q[idx_q]) begin
						gate_q[idx_q]  <= 1'b1;
						fired_q[idx_q] <= 1'b1;
					end
					st_q <= ST_NEXT;
				end
				ST_NEXT: begin
					idx_q <= idx_q + 1'b1;
					if (int'(idx_q) == rcpg_pkg::OUTPUT_COUNT - 1) st_q <= ST_DONE;
					else st_q <= ST_SEL;
				end
				ST_DONE: begin
					if (res_take) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign idle      = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_DONE);
	assign res.fired = rcpg_pkg::out_mask(fired_q);
	assign res.gates = rcpg_pkg::out_mask(gate_q);
	assign res.beat  = beat_q;

endmodule
